// File: design/rgb_to_hsv_8bit_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_8BIT_ASSERT_SVH
`define RGB_TO_HSV_8BIT_ASSERT_SVH

// Same-cycle implication, sampled at the rising clock edge.
`define HSV8_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("rgb_to_hsv_8bit check failed");

// Next-cycle implication, sampled at the rising clock edge.
`define HSV8_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("rgb_to_hsv_8bit check failed");

`endif

// File: design/hsv8_pkg.sv
// ----------------------------------------------------------------------------
// hsv8_pkg
// Widths, pipeline records and the shared divider step for the RGB to HSV
// converter.
// ----------------------------------------------------------------------------
package hsv8_pkg;

    localparam int CH_W       = 8;
    localparam int RGB_W      = 3 * CH_W;
    localparam int DIFF_W     = CH_W + 1;
    localparam int NUM_W      = 11;
    localparam int REM_W      = 19;
    localparam int DVS_W      = 11;
    localparam int QUO_W      = 8;
    localparam int QIDX_W     = $clog2(QUO_W);
    localparam int DIV_STAGES = QUO_W / 2;

    // Sector of the largest channel, red first on ties.
    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // After the max/min stage.
    typedef struct packed {
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   delta;
        logic [1:0]        khalf;
        logic [DIFF_W-1:0] diff;
    } stage_a_t;

    // After the numerator stage.
    typedef struct packed {
        logic [CH_W-1:0]  mx;
        logic [CH_W-1:0]  delta;
        logic [NUM_W-1:0] num;
    } stage_b_t;

    // One long division in flight.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVS_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    // One pixel in the divider pipeline.
    typedef struct packed {
        div_lane_t       hue;
        div_lane_t       sat;
        logic [CH_W-1:0] val;
        logic            hue_zero;
        logic            sat_zero;
    } div_item_t;

    // One restoring division step that settles quotient bit idx.
    function automatic div_lane_t div_step(input div_lane_t lane,
                                           input logic [QIDX_W-1:0] idx);
        div_lane_t        res;
        logic [REM_W-1:0] sub;
        res = lane;
        sub = REM_W'(lane.dvs) << idx;
        if (lane.rem >= sub)
        begin
            res.rem      = lane.rem - sub;
            res.quo[idx] = 1'b1;
        end
        return res;
    endfunction

endpackage

// File: design/hsv8_pix_if.sv
// ----------------------------------------------------------------------------
// hsv8_pix_if
// Pixel channel: one packed RGB word per beat.
// ----------------------------------------------------------------------------
interface hsv8_pix_if import hsv8_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [RGB_W-1:0] rgb_word;

    modport source (output valid, output rgb_word, input ready);
    modport sink   (input valid, input rgb_word, output ready);

endinterface

// File: design/hsv8_hsv_if.sv
// ----------------------------------------------------------------------------
// hsv8_hsv_if
// Result channel: hue, saturation and value bytes per beat.
// ----------------------------------------------------------------------------
interface hsv8_hsv_if import hsv8_pkg::*; ();

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] hue_byte;
    logic [CH_W-1:0] sat_byte;
    logic [CH_W-1:0] val_byte;

    modport source (output valid, output hue_byte, output sat_byte, output val_byte,
                    input ready);
    modport sink   (input valid, input hue_byte, input sat_byte, input val_byte,
                    output ready);

endinterface

// File: design/hsv8_prep.sv
// ----------------------------------------------------------------------------
// hsv8_prep
// Three pipeline stages: max/min and sector, hue numerator, then the
// dividends and divisors for the hue and saturation divisions.
// ----------------------------------------------------------------------------
module hsv8_prep import hsv8_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RGB_W-1:0] rgb_word,
    output logic             out_valid,
    input  logic             out_ready,
    output div_item_t        out_item
);

    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] mx;
    logic [CH_W-1:0] mn;
    sector_t         sector;

    stage_a_t  a_next;
    stage_a_t  a_reg;
    stage_b_t  b_next;
    stage_b_t  b_reg;
    div_item_t c_next;
    div_item_t c_reg;
    logic      a_valid_reg;
    logic      b_valid_reg;
    logic      c_valid_reg;
    logic      a_en;
    logic      b_en;
    logic      c_en;

    logic [NUM_W-1:0] base;

    // A stage loads whenever it is empty or the stage after it moves.
    assign c_en     = !c_valid_reg || out_ready;
    assign b_en     = !b_valid_reg || c_en;
    assign a_en     = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // Stage A: largest and smallest channel, sector and signed difference.
    assign red   = rgb_word[RGB_W-1 -: CH_W];
    assign green = rgb_word[2*CH_W-1 -: CH_W];
    assign blue  = rgb_word[CH_W-1:0];

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        if (mx == red)
        begin
            sector = SEC_RED;
        end
        else if (mx == green)
        begin
            sector = SEC_GREEN;
        end
        else
        begin
            sector = SEC_BLUE;
        end

        a_next.mx    = mx;
        a_next.delta = mx - mn;
        unique case (sector)
            SEC_RED:
            begin
                // Below the red axis the hue wraps to the top of the circle.
                a_next.khalf = (green < blue) ? 2'd3 : 2'd0;
                a_next.diff  = DIFF_W'(green) - DIFF_W'(blue);
            end
            SEC_GREEN:
            begin
                a_next.khalf = 2'd1;
                a_next.diff  = DIFF_W'(blue) - DIFF_W'(red);
            end
            SEC_BLUE:
            begin
                a_next.khalf = 2'd2;
                a_next.diff  = DIFF_W'(red) - DIFF_W'(green);
            end
            default:
            begin
                a_next.khalf = 2'd0;
                a_next.diff  = '0;
            end
        endcase
    end

    // Stage B: numerator k*delta + diff, which always lies below 6*delta.
    always_comb
    begin
        case (a_reg.khalf)
            2'd0:    base = '0;
            2'd1:    base = NUM_W'({a_reg.delta, 1'b0});
            2'd2:    base = NUM_W'({a_reg.delta, 2'b0});
            default: base = NUM_W'({a_reg.delta, 2'b0}) + NUM_W'({a_reg.delta, 1'b0});
        endcase
        b_next.mx    = a_reg.mx;
        b_next.delta = a_reg.delta;
        b_next.num   = base + {{(NUM_W-DIFF_W){a_reg.diff[DIFF_W-1]}}, a_reg.diff};
    end

    // Stage C: scale both dividends by 255 and form the divisors.
    always_comb
    begin
        c_next.hue.rem  = REM_W'({b_reg.num, 8'd0}) - REM_W'(b_reg.num);
        c_next.hue.dvs  = DVS_W'({b_reg.delta, 2'b0}) + DVS_W'({b_reg.delta, 1'b0});
        c_next.hue.quo  = '0;
        c_next.sat.rem  = REM_W'({b_reg.delta, 8'd0}) - REM_W'(b_reg.delta);
        c_next.sat.dvs  = DVS_W'(b_reg.mx);
        c_next.sat.quo  = '0;
        c_next.val      = b_reg.mx;
        c_next.hue_zero = (b_reg.delta == '0);
        c_next.sat_zero = (b_reg.mx == '0);
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_reg <= a_next;
        end
        if (b_en)
        begin
            b_reg <= b_next;
        end
        if (c_en)
        begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_reg;

endmodule

// File: design/hsv8_div.sv
// ----------------------------------------------------------------------------
// hsv8_div
// Pipelined restoring divider for the hue and saturation lanes side by side,
// two quotient bits per stage.
// ----------------------------------------------------------------------------
module hsv8_div import hsv8_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    div_item_t             stg_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES:0]   en;

    assign en[DIV_STAGES] = out_ready;
    assign in_ready       = en[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        localparam logic [QIDX_W-1:0] HI = QIDX_W'(QUO_W - 1 - 2 * k);
        localparam logic [QIDX_W-1:0] LO = QIDX_W'(QUO_W - 2 - 2 * k);

        div_item_t src;
        div_item_t stg_next;
        logic      src_valid;

        if (k == 0)
        begin : g_first
            assign src       = in_item;
            assign src_valid = in_valid;
        end
        else
        begin : g_rest
            assign src       = stg_reg[k-1];
            assign src_valid = valid_reg[k-1];
        end

        // The stage loads when empty or when its successor moves.
        assign en[k] = !valid_reg[k] || en[k+1];

        // Two dependent subtract-and-compare steps on each lane.
        always_comb
        begin
            stg_next     = src;
            stg_next.hue = div_step(div_step(src.hue, HI), LO);
            stg_next.sat = div_step(div_step(src.sat, HI), LO);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stg_reg[k] <= stg_next;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_item  = stg_reg[DIV_STAGES-1];

endmodule

// File: design/rgb_to_hsv_8bit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit: pipelined RGB to HSV converter, one pixel beat per clock unless the result side stalls.
// Eight register stages: three of prep, four divider stages, one output stage.
// Reset (rst_n, asynchronous) empties every stage; no result follows reset.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit import hsv8_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    hsv8_pix_if.sink   pix,
    hsv8_hsv_if.source hsv
);

    logic      prep_valid;
    logic      prep_ready;
    div_item_t prep_item;
    logic      div_valid;
    div_item_t div_item;
    logic      out_en;

    logic            out_valid_reg;
    logic [CH_W-1:0] hue_reg;
    logic [CH_W-1:0] sat_reg;
    logic [CH_W-1:0] val_reg;

    hsv8_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .rgb_word  (pix.rgb_word),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_item  (prep_item)
    );

    hsv8_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_item   (prep_item),
        .out_valid (div_valid),
        .out_ready (out_en),
        .out_item  (div_item)
    );

    // Output register takes a new beat when empty or being drained.
    assign out_en = !out_valid_reg || hsv.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    // Grey pixels have no hue and black pixels no saturation.
    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hue_reg <= div_item.hue_zero ? '0 : div_item.hue.quo;
            sat_reg <= div_item.sat_zero ? '0 : div_item.sat.quo;
            val_reg <= div_item.val;
        end
    end

    assign hsv.valid    = out_valid_reg;
    assign hsv.hue_byte = hue_reg;
    assign hsv.sat_byte = sat_reg;
    assign hsv.val_byte = val_reg;

endmodule

// File: design/hsv8_checker.sv
// ----------------------------------------------------------------------------
// hsv8_checker
// Port-level checks for the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb_to_hsv_8bit_assert.svh"

module hsv8_checker import hsv8_pkg::*; (
    input logic            clk,
    input logic            rst_n,
    input logic            pix_valid,
    input logic            pix_ready,
    input logic            hsv_valid,
    input logic            hsv_ready,
    input logic [CH_W-1:0] hue_byte,
    input logic [CH_W-1:0] sat_byte,
    input logic [CH_W-1:0] val_byte
);

    // A stalled result beat stays and keeps its payload.
    `HSV8_ASSERT_NEXT(a_out_hold, clk, !rst_n, hsv_valid && !hsv_ready, hsv_valid && $stable(hue_byte) && $stable(sat_byte) && $stable(val_byte))

    // Reset leaves no result on the output.
    `HSV8_ASSERT_NOW(a_reset_empty, clk, 1'b0, !rst_n, !hsv_valid)

    // When the sink takes results, the pixel side is never held off.
    `HSV8_ASSERT_NOW(a_ready_flow, clk, !rst_n, hsv_ready, pix_ready)

    // Back-pressure on pixels only comes from a stalled result beat.
    `HSV8_ASSERT_NOW(a_stall_source, clk, !rst_n, !pix_ready, hsv_valid && !hsv_ready)

endmodule

bind rgb_to_hsv_8bit hsv8_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .hsv_valid (hsv.valid),
    .hsv_ready (hsv.ready),
    .hue_byte  (hsv.hue_byte),
    .sat_byte  (hsv.sat_byte),
    .val_byte  (hsv.val_byte)
);

// File: sim/hsv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsv_checker
// Watches the pixel and result channels of the RGB to HSV converter. Every
// pixel beat taken by the block is turned into an expected hue, saturation
// and value triple by an independent integer model. Every result beat is
// compared field by field with the oldest triple still waiting.
// ----------------------------------------------------------------------------
module hsv_checker import hsv8_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    hsv8_pix_if  pix,
    hsv8_hsv_if  hsv,
    output int   fail_count,
    output int   pending
);

    localparam int unsigned FULL_SCALE = 255;
    localparam int unsigned SIX_SECTORS = 6;

    // One expected result, with the pixel that produced it for reporting.
    typedef struct packed {
        logic [RGB_W-1:0] rgb;
        logic [CH_W-1:0]  hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } hsv_expect_t;

    hsv_expect_t hsv_expected_q[$];
    int          mismatch_total;

    initial
    begin
        fail_count     = 0;
        pending        = 0;
        mismatch_total = 0;
    end

    // Exact integer HSV conversion: floors only, red wins ties, then green.
    function automatic hsv_expect_t hsv_from_rgb(input logic [RGB_W-1:0] rgb);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        int unsigned num;
        sector_t     sec;
        hsv_expect_t res;
        r  = 32'(rgb[2*CH_W +: CH_W]);
        g  = 32'(rgb[CH_W +: CH_W]);
        b  = 32'(rgb[0 +: CH_W]);
        mx = (r > g) ? r : g;
        mx = (mx > b) ? mx : b;
        mn = (r < g) ? r : g;
        mn = (mn < b) ? mn : b;
        delta   = mx - mn;
        res.rgb = rgb;
        res.val = CH_W'(mx);
        res.sat = (mx != 0) ? CH_W'((FULL_SCALE * delta) / mx) : '0;
        res.hue = '0;
        if (delta != 0)
        begin
            if (mx == r)
                sec = SEC_RED;
            else if (mx == g)
                sec = SEC_GREEN;
            else
                sec = SEC_BLUE;
            case (sec)
                SEC_RED:
                    // Red sector wraps to the top of the circle when blue leads green.
                    num = (g >= b) ? (g - b) : (SIX_SECTORS * delta - (b - g));
                SEC_GREEN:
                    num = 2 * delta + b - r;
                default:
                    num = 4 * delta + r - g;
            endcase
            res.hue = CH_W'((FULL_SCALE * num) / (SIX_SECTORS * delta));
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [RGB_W-1:0] rgb,
                               input logic [CH_W-1:0] want, input logic [CH_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch for pixel 0x%06h: expected %0d, actual %0d",
                     $time, name, rgb, want, got);
            mismatch_total++;
        end
    endtask

    // Collect expectations on pixel beats and check result beats.
    always @(posedge clk)
    begin
        hsv_expect_t want;
        if (rst_n)
        begin
            if (pix.valid === 1'b1 && pix.ready === 1'b1)
                hsv_expected_q.push_back(hsv_from_rgb(pix.rgb_word));
            if (hsv.valid === 1'b1 && hsv.ready === 1'b1)
            begin
                if (hsv_expected_q.size() == 0)
                begin
                    $display("%0t: result beat with none expected: expected none, actual h=%0d s=%0d v=%0d",
                             $time, hsv.hue_byte, hsv.sat_byte, hsv.val_byte);
                    mismatch_total++;
                end
                else
                begin
                    want = hsv_expected_q.pop_front();
                    check_field("hue", want.rgb, want.hue, hsv.hue_byte);
                    check_field("sat", want.rgb, want.sat, hsv.sat_byte);
                    check_field("val", want.rgb, want.val, hsv.val_byte);
                end
            end
            pending    <= hsv_expected_q.size();
            fail_count <= mismatch_total;
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pixel beats into the RGB to HSV converter: a directed set of corner
// pixels first, then random pixels weighted toward grey, tied and narrow
// ranges. Both channels idle at random, and the result side holds off once
// long enough to back the pipeline up. The checker reports mismatches.
// ----------------------------------------------------------------------------
module tb_top import hsv8_pkg::*; ();

    localparam int RANDOM_PIXELS  = 700;
    localparam int STALL_AT       = 200;
    localparam int STALL_CYCLES   = 80;
    localparam int QUIET_AT       = 600;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_DIRECTED   = 22;

    // Black, white, primaries, grey, ties, red wrap, smallest values.
    localparam logic [RGB_W-1:0] DIRECTED_PX [NUM_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0010, 24'hFF1000, 24'h10FF00,
        24'h00FF10, 24'h1000FF, 24'h0010FF, 24'h010000, 24'h000001, 24'h000100,
        24'h7F8081, 24'hFEFFFE, 24'h55AA00, 24'hFFFEFF
    };

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   sent_count;
    bit   quiet_phase;
    int   idle_cycles;

    hsv8_pix_if pix ();
    hsv8_hsv_if hsv ();

    rgb_to_hsv_8bit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .hsv   (hsv)
    );

    hsv_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix),
        .hsv        (hsv),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Random pixel, mostly shaped toward the interesting corners.
    function automatic logic [RGB_W-1:0] random_pixel();
        logic [CH_W-1:0] c [3];
        int unsigned     kind;
        int unsigned     hi;
        int unsigned     lead;
        kind = $urandom_range(0, 9);
        lead = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++)
            c[i] = CH_W'($urandom);
        case (kind) inside
            4:
            begin
                // Grey.
                c[1] = c[0];
                c[2] = c[0];
            end
            5, 6:
            begin
                // One or two channels share the maximum.
                hi = $urandom_range(1, 255);
                for (int i = 0; i < 3; i++)
                    c[i] = CH_W'($urandom_range(0, hi - 1));
                c[lead] = CH_W'(hi);
                if (kind == 5)
                    c[(lead + 1) % 3] = CH_W'(hi);
            end
            7:
            begin
                // Narrow spread around a mid value.
                hi = $urandom_range(2, 253);
                for (int i = 0; i < 3; i++)
                    c[i] = CH_W'(hi + $urandom_range(0, 4) - 2);
            end
            8:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = CH_W'($urandom_range(0, 3));
            end
            9:
            begin
                for (int i = 0; i < 3; i++)
                    c[i] = CH_W'($urandom_range(252, 255));
            end
            default:
            begin
            end
        endcase
        return {c[0], c[1], c[2]};
    endfunction

    // Offer one pixel beat, after an optional idle burst, and wait until taken.
    task automatic send_pixel(input logic [RGB_W-1:0] px);
        int gap;
        gap = 0;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            pix.valid    <= 1'b0;
            pix.rgb_word <= RGB_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.rgb_word <= px;
        @(posedge clk);
        while (pix.ready !== 1'b1)
            @(posedge clk);
        sent_count++;
    endtask

    // Reset, stimulus and verdict.
    initial
    begin
        rst_n        = 1'b0;
        pix.valid    = 1'b0;
        pix.rgb_word = '0;
        hsv.ready    = 1'b0;
        sent_count   = 0;
        quiet_phase  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PX[i])
            send_pixel(DIRECTED_PX[i]);
        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n == QUIET_AT)
                quiet_phase = 1'b1;
            send_pixel(random_pixel());
        end
        pix.valid <= 1'b0;

        // Drain, then give the pipeline time to show any stray beat.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Result side: short random hold-offs, one long one to fill the pipeline.
    initial
    begin
        bit long_stall_done;
        long_stall_done = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!long_stall_done && sent_count >= STALL_AT)
            begin
                hsv.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                long_stall_done = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                hsv.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            hsv.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog on cycles in which neither channel moves a beat.
    initial
        idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((pix.valid === 1'b1 && pix.ready === 1'b1) ||
            (hsv.valid === 1'b1 && hsv.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule

// File: filelist.f
+incdir+design
design/hsv8_pkg.sv
design/hsv8_pix_if.sv
design/hsv8_hsv_if.sv
design/hsv8_prep.sv
design/hsv8_div.sv
design/rgb_to_hsv_8bit.sv
design/hsv8_checker.sv
sim/hsv_checker.sv
sim/tb_top.sv
